>>> hdl/wsfd_pkg.sv
package wsfd_pkg;

    localparam int LEN_BITS = 16;

    typedef enum logic [1:0] {
        STATUS_DATA      = 2'd0,
        STATUS_REJECTED  = 2'd1,
        STATUS_EMPTY     = 2'd2,
        STATUS_TOO_LARGE = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_byte;
        logic       binary_frame;
        status_t    frame_status;
    } result_t;

endpackage

>>> hdl/wsfd_parser.sv
module wsfd_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          rx_byte,
    output logic                res_valid,
    output wsfd_pkg::result_t   res
);

    localparam logic [6:0] OPC_TEXT       = 7'h01;
    localparam logic [6:0] OPC_BINARY     = 7'h02;
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES    = 4'd2;
    localparam logic [3:0] EXT64_BYTES    = 4'd8;
    localparam logic [3:0] MASK_BYTES     = 4'd4;

    typedef enum logic [2:0] {
        PH_HDR    = 3'd0,
        PH_LEN    = 3'd1,
        PH_EXT16  = 3'd2,
        PH_EXT64  = 3'd3,
        PH_MASK   = 3'd4,
        PH_DATA   = 3'd5,
        PH_CLOSED = 3'd6
    } phase_t;

    localparam int LB = wsfd_pkg::LEN_BITS;

    phase_t          phase_reg, phase_next;
    logic [3:0]      count_reg, count_next;
    logic [LB-1:0]   length_reg, length_next;
    logic            overflow_reg, overflow_next;
    logic [31:0]     key_reg, key_next;
    logic            masked_reg, masked_next;
    logic [LB-1:0]   index_reg, index_next;
    logic            binary_reg, binary_next;

    logic            after_len;
    logic            hdr_done;
    logic            chk_mask;
    logic            chk_ovf;
    logic [LB-1:0]   chk_len;
    logic [3:0]      count_inc;
    logic [3:0]      ext_limit;
    logic [LB+7:0]   shifted_len;
    logic [LB-1:0]   index_inc;
    logic [7:0]      key_byte;

    assign count_inc   = count_reg + 4'd1;
    assign ext_limit   = (phase_reg == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES;
    assign shifted_len = {length_reg, rx_byte};
    assign index_inc   = index_reg + {{(LB-1){1'b0}}, 1'b1};
    assign key_byte    = masked_reg ? key_reg[{~index_reg[1:0], 3'b000} +: 8] : 8'h00;

    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        length_next   = length_reg;
        overflow_next = overflow_reg;
        key_next      = key_reg;
        masked_next   = masked_reg;
        index_next    = index_reg;
        binary_next   = binary_reg;
        res_valid     = 1'b0;
        res           = '{payload_byte: 8'h00, last_byte: 1'b0, binary_frame: binary_reg,
                          frame_status: wsfd_pkg::STATUS_DATA};
        after_len     = 1'b0;
        hdr_done      = 1'b0;
        chk_mask      = masked_reg;
        chk_ovf       = overflow_reg;
        chk_len       = length_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_HDR: begin
                    if (!rx_byte[7] || (rx_byte[6:0] != OPC_TEXT && rx_byte[6:0] != OPC_BINARY))
                    begin
                        phase_next       = PH_CLOSED;
                        res_valid        = 1'b1;
                        res.binary_frame = 1'b0;
                        res.frame_status = wsfd_pkg::STATUS_REJECTED;
                    end else begin
                        binary_next = (rx_byte[6:0] == OPC_BINARY);
                        phase_next  = PH_LEN;
                    end
                end
                PH_LEN: begin
                    masked_next   = rx_byte[7];
                    chk_mask      = rx_byte[7];
                    length_next   = '0;
                    overflow_next = 1'b0;
                    key_next      = '0;
                    count_next    = '0;
                    if (rx_byte[6:0] == LEN_CODE_EXT16) begin
                        phase_next = PH_EXT16;
                    end else if (rx_byte[6:0] == LEN_CODE_EXT64) begin
                        phase_next = PH_EXT64;
                    end else begin
                        length_next = {{(LB-7){1'b0}}, rx_byte[6:0]};
                        chk_len     = length_next;
                        chk_ovf     = 1'b0;
                        after_len   = 1'b1;
                    end
                end
                PH_EXT16, PH_EXT64: begin
                    overflow_next = overflow_reg | (length_reg[LB-1 -: 8] != 8'h00);
                    length_next   = shifted_len[LB-1:0];
                    count_next    = count_inc;
                    chk_ovf       = overflow_next;
                    chk_len       = length_next;
                    after_len     = (count_inc >= ext_limit);
                end
                PH_MASK: begin
                    key_next   = {key_reg[23:0], rx_byte};
                    count_next = count_inc;
                    if (count_inc >= MASK_BYTES) begin
                        count_next = '0;
                        hdr_done   = 1'b1;
                    end
                end
                PH_DATA: begin
                    res_valid        = 1'b1;
                    res.payload_byte = rx_byte ^ key_byte;
                    if (index_inc == length_reg) begin
                        res.last_byte = 1'b1;
                        phase_next    = PH_HDR;
                        index_next    = '0;
                    end else begin
                        index_next = index_inc;
                    end
                end
                default: phase_next = PH_CLOSED;
            endcase
        end
        if (after_len) begin
            count_next = '0;
            if (chk_mask) begin
                phase_next = PH_MASK;
            end else begin
                hdr_done = 1'b1;
            end
        end
        if (hdr_done) begin
            if (chk_ovf) begin
                phase_next       = PH_CLOSED;
                res_valid        = 1'b1;
                res.frame_status = wsfd_pkg::STATUS_TOO_LARGE;
            end else if (chk_len == '0) begin
                phase_next       = PH_CLOSED;
                res_valid        = 1'b1;
                res.frame_status = wsfd_pkg::STATUS_EMPTY;
            end else begin
                index_next = '0;
                phase_next = PH_DATA;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HDR;
            count_reg    <= '0;
            length_reg   <= '0;
            overflow_reg <= 1'b0;
            key_reg      <= '0;
            masked_reg   <= 1'b0;
            index_reg    <= '0;
            binary_reg   <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            length_reg   <= length_next;
            overflow_reg <= overflow_next;
            key_reg      <= key_next;
            masked_reg   <= masked_next;
            index_reg    <= index_next;
            binary_reg   <= binary_next;
        end
    end

    closed_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_CLOSED |=> phase_reg == PH_CLOSED)
        else $error("closed parser reopened");

    error_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.frame_status != wsfd_pkg::STATUS_DATA |=> phase_reg == PH_CLOSED)
        else $error("error status without closing");

    last_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.last_byte |=> phase_reg == PH_HDR && index_reg == '0)
        else $error("last byte did not return to header phase");

    index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> index_reg < length_reg)
        else $error("payload index beyond frame length");

endmodule

>>> hdl/wsfd_out_buf.sv
module wsfd_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  wsfd_pkg::result_t   in_data,
    output logic                in_ready,
    output logic                out_valid,
    output wsfd_pkg::result_t   out_data,
    input  logic                out_ready
);

    logic              out_valid_reg, out_valid_next;
    wsfd_pkg::result_t out_data_reg, out_data_next;
    logic              skid_valid_reg, skid_valid_next;
    wsfd_pkg::result_t skid_data_reg, skid_data_next;
    logic              pop;

    assign pop       = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = in_valid;
                skid_data_next  = in_data;
            end else begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

>>> hdl/websocket_frame_deframer.sv
// Receive-side WebSocket frame deframer: takes one stream byte per cycle on
// s_rx_byte while s_ready is high, parses the frame header (FIN and
// text/binary opcode, length byte, 16-bit or 64-bit big-endian extended
// length, optional 4-byte mask key) and returns each payload byte unmasked,
// with m_last_byte on the final one; header bytes produce no transaction.
// The parser is combinational, so the block sustains one byte per clock;
// its only stall is the two-entry output register and skid stage filling
// up when m_ready is held low. A non-final frame, an opcode other than
// text or binary, an empty frame or a length above 65535 returns one error
// transaction and the block then swallows every byte until reset.
module websocket_frame_deframer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_payload_byte,
    output logic       m_last_byte,
    output logic       m_binary_frame,
    output logic [1:0] m_frame_status
);

    logic              accept;
    logic              res_valid;
    wsfd_pkg::result_t res;
    wsfd_pkg::result_t out_data;

    assign accept = s_valid && s_ready;

    wsfd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .rx_byte   (s_rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    wsfd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_data  (out_data),
        .out_ready (m_ready)
    );

    assign m_payload_byte = out_data.payload_byte;
    assign m_last_byte    = out_data.last_byte;
    assign m_binary_frame = out_data.binary_frame;
    assign m_frame_status = out_data.frame_status;

endmodule
